/* sv/ssw_pkg.sv */
`timescale 1ns / 1ps

package ssw_pkg;

   localparam int ByteW    = 8;
   localparam int CountW   = 22;
   localparam int PauseW   = 16;
   localparam int DigitW   = 4;
   localparam int PhaseW   = 2;
   localparam int PinW     = 6;
   localparam int ModeW    = 3;

   localparam logic [ModeW-1:0] MODE_IDLE   = 3'd0;
   localparam logic [ModeW-1:0] MODE_CMD    = 3'd1;
   localparam logic [ModeW-1:0] MODE_PARAMS = 3'd2;
   localparam logic [ModeW-1:0] MODE_STEP   = 3'd3;
   localparam logic [ModeW-1:0] MODE_HELD   = 3'd4;

   localparam logic [ByteW-1:0] HASH_BYTE  = 8'd35;
   localparam logic [ByteW-1:0] DIGIT_ZERO = 8'd48;
   localparam logic [ByteW-1:0] CHAR_ONE   = 8'd49;
   localparam logic [ByteW-1:0] CHAR_TWO   = 8'd50;

   localparam logic [PauseW-1:0] PAUSE_NUMERATOR = 16'd60000;
   localparam logic [DigitW-1:0] LAST_DIGIT      = 4'd10;
   localparam logic [DigitW-1:0] LAST_STEP_DIGIT = 4'd5;

   // pin bits: 0 ena, 1 in1, 2 in2, 3 enb, 4 in3, 5 in4
   localparam int PIN_ENA = 0;
   localparam int PIN_IN1 = 1;
   localparam int PIN_IN2 = 2;
   localparam int PIN_ENB = 3;
   localparam int PIN_IN3 = 4;
   localparam int PIN_IN4 = 5;

   typedef struct packed {
      logic              done;
      logic [PauseW-1:0] quotient;
   } div_result_type;

   function automatic logic [PinW-1:0] drive_phase(input logic [PinW-1:0] pins,
                                                   input logic [PhaseW-1:0] phase,
                                                   input logic [ByteW-1:0] dir);
      logic [PhaseW-1:0] p;
      logic [PinW-1:0]   r;
      begin
         p = (dir == CHAR_TWO) ? ~phase : phase;
         r = pins;
         case (p)
            2'd0: begin
               r[PIN_ENA] = 1'b1; r[PIN_IN1] = 1'b1; r[PIN_IN2] = 1'b0;
            end
            2'd1: begin
               r[PIN_ENB] = 1'b1; r[PIN_IN3] = 1'b1; r[PIN_IN4] = 1'b0;
            end
            2'd2: begin
               r[PIN_ENA] = 1'b1; r[PIN_IN2] = 1'b1; r[PIN_IN1] = 1'b0;
            end
            default: begin
               r[PIN_ENB] = 1'b1; r[PIN_IN4] = 1'b1; r[PIN_IN3] = 1'b0;
            end
         endcase
         return r;
      end
   endfunction

endpackage

/* sv/ssw_req_if.sv */
`timescale 1ns / 1ps

interface ssw_req_if import ssw_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             command;
   logic [ByteW-1:0] rx_byte;

   modport source (output valid, output command, output rx_byte, input ready);
   modport sink   (input valid, input command, input rx_byte, output ready);
endinterface

/* sv/ssw_rsp_if.sv */
`timescale 1ns / 1ps

interface ssw_rsp_if import ssw_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              ena;
   logic              in1;
   logic              in2;
   logic              enb;
   logic              in3;
   logic              in4;
   logic [ModeW-1:0]  mode;
   logic [CountW-1:0] steps_left;

   modport source (output valid, output ena, output in1, output in2, output enb,
                   output in3, output in4, output mode, output steps_left,
                   input ready);
   modport sink   (input valid, input ena, input in1, input in2, input enb,
                   input in3, input in4, input mode, input steps_left,
                   output ready);
endinterface

/* sv/ssw_div.sv */
`timescale 1ns / 1ps

module ssw_div import ssw_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [CountW-1:0]   divisor,
   output div_result_type      result
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [3:0]        cnt_ff, cnt_in;
   logic [CountW-1:0] div_ff, div_in;
   logic [CountW-1:0] rem_ff, rem_in;
   logic [PauseW-1:0] quo_ff, quo_in;
   logic [CountW:0]   rem_sh;
   logic              ge;

   // restoring division, one quotient bit per cycle
   always_comb begin
      rem_sh  = {rem_ff, quo_ff[PauseW-1]};
      ge      = rem_sh >= {1'b0, div_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 4'd15;
         div_in  = divisor;
         rem_in  = '0;
         quo_in  = PAUSE_NUMERATOR;
      end else if (busy_ff) begin
         rem_in = ge ? CountW'(rem_sh - {1'b0, div_ff}) : rem_sh[CountW-1:0];
         quo_in = {quo_ff[PauseW-2:0], ge};
         cnt_in = cnt_ff - 4'd1;
         if (cnt_ff == 4'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      div_ff <= div_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign result.done     = done_ff;
   assign result.quotient = quo_ff;

endmodule

/* sv/serial_stepper_wave_drive_sequencer.sv */
`timescale 1ns / 1ps
// a tick and most bytes, once accepted, have their result registered and valid in the next cycle
// the byte that ends parameter reception starts a 16-step divider that computes the pause,
// one bit per cycle; its done loads the result, and the block is not ready meanwhile
// throughput: otherwise one transaction per cycle while results are taken; the result register frees on the same edge
// reset: synchronous, active high; clears the parser, counters and pin latch to idle/low

module serial_stepper_wave_drive_sequencer import ssw_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   ssw_req_if.sink    req_chan,
   ssw_rsp_if.source  rsp_chan
);

   localparam logic S_READY  = 1'b0;
   localparam logic S_DIVIDE = 1'b1;

   logic              seq_ff, seq_in;
   logic [ModeW-1:0]  mode_ff, mode_in;
   logic [DigitW-1:0] digit_ff, digit_in;
   logic [ByteW-1:0]  dir_ff, dir_in;
   logic [CountW-1:0] steps_ff, steps_in;
   logic [CountW-1:0] speed_ff, speed_in;
   logic [PauseW-1:0] pause_ff, pause_in;
   logic [PauseW-1:0] delay_ff, delay_in;
   logic [PhaseW-1:0] phase_ff, phase_in;
   logic [PinW-1:0]   pins_ff, pins_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [PinW-1:0]   rsp_pins_ff;
   logic [ModeW-1:0]  rsp_mode_ff;
   logic [CountW-1:0] rsp_steps_ff;

   logic              accept;
   logic              rsp_load;
   logic              div_start;
   div_result_type    div_res;
   logic [ByteW-1:0]  digit;
   logic [CountW-1:0] mul_src;
   logic [CountW-1:0] mul_out;
   logic [PauseW-1:0] delay_dec;
   logic [PauseW-1:0] pause_calc;

   ssw_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .divisor (speed_in),
      .result  (div_res)
   );

   assign req_chan.ready = (seq_ff == S_READY) && (!rsp_valid_ff || rsp_chan.ready);
   assign accept         = req_chan.valid && req_chan.ready;

   assign digit   = req_chan.rx_byte - DIGIT_ZERO;
   assign mul_src = (digit_ff <= LAST_STEP_DIGIT) ? steps_ff : speed_ff;
   assign mul_out = CountW'({mul_src, 3'b000} + {mul_src, 1'b0} + CountW'(digit));
   assign delay_dec = (delay_ff != '0) ? delay_ff - 16'd1 : delay_ff;

   always_comb begin
      pause_calc = (speed_ff == '0) ? PAUSE_NUMERATOR : div_res.quotient;
      if (pause_calc == '0) begin
         pause_calc = 16'd1;
      end
   end

   always_comb begin
      seq_in    = seq_ff;
      mode_in   = mode_ff;
      digit_in  = digit_ff;
      dir_in    = dir_ff;
      steps_in  = steps_ff;
      speed_in  = speed_ff;
      pause_in  = pause_ff;
      delay_in  = delay_ff;
      phase_in  = phase_ff;
      pins_in   = pins_ff;
      rsp_load  = 1'b0;
      div_start = 1'b0;
      case (seq_ff)
         S_READY: begin
            if (accept) begin
               rsp_load = 1'b1;
               if (req_chan.command) begin
                  case (mode_ff)
                     MODE_IDLE: begin
                        if (req_chan.rx_byte == HASH_BYTE) begin
                           mode_in = MODE_CMD;
                        end
                     end
                     MODE_CMD, MODE_HELD: begin
                        if (req_chan.rx_byte == CHAR_TWO) begin
                           mode_in  = MODE_PARAMS;
                           digit_in = '0;
                        end else begin
                           mode_in = MODE_IDLE;
                        end
                     end
                     MODE_PARAMS: begin
                        if (digit_ff == '0) begin
                           dir_in   = req_chan.rx_byte;
                           steps_in = '0;
                           speed_in = '0;
                        end else if (digit_ff <= LAST_STEP_DIGIT) begin
                           steps_in = mul_out;
                        end else begin
                           speed_in = mul_out;
                        end
                        digit_in = digit_ff + 4'd1;
                        if (digit_ff == LAST_DIGIT) begin
                           digit_in  = '0;
                           div_start = 1'b1;
                           rsp_load  = 1'b0;
                           seq_in    = S_DIVIDE;
                        end
                     end
                     MODE_STEP: begin
                        if (req_chan.rx_byte == HASH_BYTE) begin
                           mode_in = MODE_HELD;
                        end
                     end
                     default: begin
                        mode_in = MODE_IDLE;
                     end
                  endcase
               end else if (mode_ff == MODE_STEP) begin
                  delay_in = delay_dec;
                  if (delay_dec == '0) begin
                     steps_in = steps_ff - 22'd1;
                     if (steps_in == '0) begin
                        mode_in = MODE_IDLE;
                     end else begin
                        phase_in = phase_ff + 2'd1;
                        pins_in  = drive_phase(pins_ff, phase_in, dir_ff);
                        delay_in = pause_ff;
                     end
                  end
               end
            end
         end
         S_DIVIDE: begin
            if (div_res.done) begin
               seq_in   = S_READY;
               rsp_load = 1'b1;
               pause_in = pause_calc;
               if ((dir_ff != CHAR_ONE && dir_ff != CHAR_TWO) || steps_ff == '0) begin
                  mode_in = MODE_IDLE;
               end else begin
                  mode_in  = MODE_STEP;
                  phase_in = '0;
                  pins_in  = drive_phase(pins_ff, 2'd0, dir_ff);
                  delay_in = pause_calc;
               end
            end
         end
         default: begin
            seq_in = S_READY;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff       <= S_READY;
         mode_ff      <= MODE_IDLE;
         digit_ff     <= '0;
         dir_ff       <= '0;
         steps_ff     <= '0;
         speed_ff     <= '0;
         pause_ff     <= '0;
         delay_ff     <= '0;
         phase_ff     <= '0;
         pins_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         seq_ff       <= seq_in;
         mode_ff      <= mode_in;
         digit_ff     <= digit_in;
         dir_ff       <= dir_in;
         steps_ff     <= steps_in;
         speed_ff     <= speed_in;
         pause_ff     <= pause_in;
         delay_ff     <= delay_in;
         phase_ff     <= phase_in;
         pins_ff      <= pins_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (rsp_load) begin
         rsp_pins_ff  <= pins_in;
         rsp_mode_ff  <= mode_in;
         rsp_steps_ff <= (mode_in == MODE_STEP || mode_in == MODE_HELD) ? steps_in : '0;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.ena        = rsp_pins_ff[PIN_ENA];
   assign rsp_chan.in1        = rsp_pins_ff[PIN_IN1];
   assign rsp_chan.in2        = rsp_pins_ff[PIN_IN2];
   assign rsp_chan.enb        = rsp_pins_ff[PIN_ENB];
   assign rsp_chan.in3        = rsp_pins_ff[PIN_IN3];
   assign rsp_chan.in4        = rsp_pins_ff[PIN_IN4];
   assign rsp_chan.mode       = rsp_mode_ff;
   assign rsp_chan.steps_left = rsp_steps_ff;

   // no new transaction while the divider runs
   assert property (@(posedge clock) disable iff (reset)
      seq_ff == S_DIVIDE |-> !req_chan.ready)
      else $error("transaction taken during divide");

   // divider result only arrives while waiting for it
   assert property (@(posedge clock) disable iff (reset)
      div_res.done |-> seq_ff == S_DIVIDE)
      else $error("unexpected divider completion");

   // stepping or held always has steps outstanding
   assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_STEP || mode_ff == MODE_HELD) |-> steps_ff != '0)
      else $error("stepping with zero steps");

   // parameter byte counter never passes the last speed digit
   assert property (@(posedge clock) disable iff (reset)
      digit_ff <= LAST_DIGIT)
      else $error("digit counter out of range");

   // entering divide leaves the result register empty
   assert property (@(posedge clock) disable iff (reset)
      div_start |=> !rsp_valid_ff)
      else $error("result pending at divide start");

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
   import ssw_pkg::*;

   localparam logic CMD_TICK = 1'b0;
   localparam logic CMD_BYTE = 1'b1;

   localparam logic [ByteW-1:0] SLASH_BYTE = 8'd47;
   localparam logic [ByteW-1:0] CHAR_THREE = 8'd51;

   localparam int ItemTarget  = 1400;
   localparam int QuietTail   = 150;
   localparam int StallLimit  = 2000;
   localparam int DrainCycles = 40;
   localparam int MaxReports  = 10;

   typedef struct packed {
      logic             command;
      logic [ByteW-1:0] rx_byte;
   } serial_item_type;

   typedef struct packed {
      logic [PinW-1:0]   pins;
      logic [ModeW-1:0]  mode;
      logic [CountW-1:0] steps_left;
   } drive_state_type;

   logic clock;
   logic reset;

   ssw_req_if req_if ();
   ssw_rsp_if rsp_if ();

   serial_stepper_wave_drive_sequencer u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   serial_item_type serial_feed_q[$];
   drive_state_type expected_drive_q[$];

   int total_items    = 0;
   int sent_count     = 0;
   int accepted_count = 0;
   int checked_count  = 0;
   int mismatch_count = 0;
   int tick_count     = 0;
   int byte_count     = 0;
   int sets_decoded   = 0;
   int steps_done     = 0;
   int send_gap       = 0;
   int rsp_stall      = 0;
   int idle_cycles    = 0;
   logic req_taken    = 1'b0;

   // sequencer state mirror
   logic [ModeW-1:0]  seq_mode;
   logic [DigitW-1:0] seq_digits;
   logic [ByteW-1:0]  seq_dir;
   logic [CountW-1:0] seq_steps;
   logic [CountW-1:0] seq_speed;
   logic [PauseW-1:0] seq_pause;
   logic [PauseW-1:0] seq_delay;
   logic [PhaseW-1:0] seq_phase;
   logic [PinW-1:0]   seq_pins;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void push_byte(logic [ByteW-1:0] b);
      serial_feed_q.push_back(serial_item_type'{command: CMD_BYTE, rx_byte: b});
   endfunction

   function automatic void push_tick();
      serial_feed_q.push_back(serial_item_type'{command: CMD_TICK,
                                                rx_byte: ByteW'($urandom)});
   endfunction

   function automatic logic [ByteW-1:0] random_non_hash();
      logic [ByteW-1:0] b;
      do b = ByteW'($urandom); while (b == HASH_BYTE);
      return b;
   endfunction

   // five decimal characters, most significant first
   function automatic void push_number(int unsigned v);
      int unsigned div;
      div = 10000;
      repeat (5) begin
         push_byte(DIGIT_ZERO + ByteW'((v / div) % 10));
         div = div / 10;
      end
   endfunction

   function automatic void push_raw_digits();
      repeat (5) push_byte(ByteW'($urandom));
   endfunction

   function automatic void drive_wave();
      logic [PhaseW-1:0] p;
      p = seq_phase;
      if (seq_dir == CHAR_TWO)
         p = 2'd3 - p;
      case (p)
         2'd0: begin
            seq_pins[PIN_ENA] = 1'b1; seq_pins[PIN_IN1] = 1'b1; seq_pins[PIN_IN2] = 1'b0;
         end
         2'd1: begin
            seq_pins[PIN_ENB] = 1'b1; seq_pins[PIN_IN3] = 1'b1; seq_pins[PIN_IN4] = 1'b0;
         end
         2'd2: begin
            seq_pins[PIN_ENA] = 1'b1; seq_pins[PIN_IN2] = 1'b1; seq_pins[PIN_IN1] = 1'b0;
         end
         default: begin
            seq_pins[PIN_ENB] = 1'b1; seq_pins[PIN_IN4] = 1'b1; seq_pins[PIN_IN3] = 1'b0;
         end
      endcase
      seq_delay = seq_pause;
   endfunction

   function automatic drive_state_type advance_sequencer(serial_item_type it);
      drive_state_type  r;
      logic [ByteW-1:0] d;
      int unsigned      q;
      if (it.command == CMD_BYTE) begin
         case (seq_mode)
            MODE_IDLE: begin
               if (it.rx_byte == HASH_BYTE)
                  seq_mode = MODE_CMD;
            end
            MODE_CMD, MODE_HELD: begin
               if (it.rx_byte == CHAR_TWO) begin
                  seq_mode   = MODE_PARAMS;
                  seq_digits = '0;
               end else begin
                  seq_mode = MODE_IDLE;
               end
            end
            MODE_PARAMS: begin
               d = it.rx_byte - DIGIT_ZERO;
               if (seq_digits == '0) begin
                  seq_dir   = it.rx_byte;
                  seq_steps = '0;
                  seq_speed = '0;
               end else if (seq_digits <= LAST_STEP_DIGIT) begin
                  seq_steps = CountW'(seq_steps * 10 + d);
               end else begin
                  seq_speed = CountW'(seq_speed * 10 + d);
               end
               seq_digits = seq_digits + 1'b1;
               if (seq_digits > LAST_DIGIT) begin
                  seq_digits = '0;
                  sets_decoded++;
                  if (seq_speed == '0)
                     q = 32'(PAUSE_NUMERATOR);
                  else
                     q = 32'(PAUSE_NUMERATOR) / 32'(seq_speed);
                  if (q == 0)
                     q = 1;
                  seq_pause = PauseW'(q);
                  if ((seq_dir != CHAR_ONE && seq_dir != CHAR_TWO) || seq_steps == '0) begin
                     seq_mode = MODE_IDLE;
                  end else begin
                     seq_mode  = MODE_STEP;
                     seq_phase = '0;
                     drive_wave();
                  end
               end
            end
            MODE_STEP: begin
               if (it.rx_byte == HASH_BYTE)
                  seq_mode = MODE_HELD;
            end
            default: seq_mode = MODE_IDLE;
         endcase
      end else if (seq_mode == MODE_STEP) begin
         if (seq_delay != '0)
            seq_delay = seq_delay - 1'b1;
         if (seq_delay == '0) begin
            seq_steps = seq_steps - 1'b1;
            steps_done++;
            if (seq_steps == '0) begin
               seq_mode = MODE_IDLE;
            end else begin
               seq_phase = seq_phase + 1'b1;
               drive_wave();
            end
         end
      end
      r.pins       = seq_pins;
      r.mode       = seq_mode;
      r.steps_left = (seq_mode == MODE_STEP || seq_mode == MODE_HELD) ? seq_steps : '0;
      return r;
   endfunction

   // driver: inputs change on the falling edge
   always @(negedge clock) begin : drive_serial
      serial_item_type item;
      logic            quiet;
      logic            bursty;
      if (reset) begin
         req_if.valid   <= 1'b0;
         req_if.command <= CMD_TICK;
         req_if.rx_byte <= '0;
         rsp_if.ready   <= 1'b0;
      end else begin
         quiet  = sent_count >= total_items - QuietTail;
         bursty = !quiet && ((sent_count / 120) % 4 != 3);
         if (req_taken || !req_if.valid) begin
            if (send_gap > 0) begin
               req_if.valid <= 1'b0;
               send_gap--;
            end else if (serial_feed_q.size() > 0) begin
               item = serial_feed_q.pop_front();
               req_if.valid   <= 1'b1;
               req_if.command <= item.command;
               req_if.rx_byte <= item.rx_byte;
               sent_count++;
               if (bursty && $urandom_range(0, 7) == 0)
                  send_gap = $urandom_range(1, 6);
            end else begin
               req_if.valid <= 1'b0;
            end
         end
         if (rsp_stall > 0) begin
            rsp_if.ready <= 1'b0;
            rsp_stall--;
         end else begin
            rsp_if.ready <= 1'b1;
            if (bursty && $urandom_range(0, 7) == 0)
               rsp_stall = $urandom_range(1, 6);
         end
      end
   end

   // monitor, predictor and watchdog on the rising edge
   always @(posedge clock) begin : check_drive
      drive_state_type seen;
      drive_state_type want;
      serial_item_type item;
      logic            req_fire;
      logic            rsp_fire;
      if (reset) begin
         seq_mode    = MODE_IDLE;
         seq_digits  = '0;
         seq_dir     = '0;
         seq_steps   = '0;
         seq_speed   = '0;
         seq_pause   = '0;
         seq_delay   = '0;
         seq_phase   = '0;
         seq_pins    = '0;
         req_taken   <= 1'b0;
         idle_cycles = 0;
      end else begin
         req_fire = req_if.valid && req_if.ready;
         rsp_fire = rsp_if.valid && rsp_if.ready;
         req_taken <= req_fire;
         if (rsp_fire) begin
            seen.pins = {rsp_if.in4, rsp_if.in3, rsp_if.enb,
                         rsp_if.in2, rsp_if.in1, rsp_if.ena};
            seen.mode       = rsp_if.mode;
            seen.steps_left = rsp_if.steps_left;
            if (expected_drive_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MaxReports)
                  $display("%0t: unexpected transaction pins=%b mode=%0d steps=%0d",
                           $time, seen.pins, seen.mode, seen.steps_left);
            end else begin
               want = expected_drive_q.pop_front();
               checked_count++;
               if (seen.pins !== want.pins || seen.mode !== want.mode ||
                   seen.steps_left !== want.steps_left) begin
                  mismatch_count++;
                  if (mismatch_count <= MaxReports)
                     $display("%0t: expected pins/mode/steps %b/%0d/%0d, got %b/%0d/%0d",
                              $time, want.pins, want.mode, want.steps_left,
                              seen.pins, seen.mode, seen.steps_left);
               end
            end
         end
         if (req_fire) begin
            item.command = req_if.command;
            item.rx_byte = req_if.rx_byte;
            expected_drive_q.push_back(advance_sequencer(item));
            accepted_count++;
            if (item.command == CMD_TICK)
               tick_count++;
            else
               byte_count++;
         end
         if (req_fire || rsp_fire)
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= StallLimit) begin
            $display("watchdog: no transaction for %0d cycles", StallLimit);
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   initial begin : run_test
      int               pick;
      int               sel;
      logic [ByteW-1:0] dir;
      reset = 1'b1;

      // directed: tick in idle, short run at minimum pause with a stray byte,
      // run to completion, then reverse with non-digit step characters and speed zero, hold, stop
      push_tick();
      push_byte(HASH_BYTE);
      push_byte(CHAR_TWO);
      push_byte(CHAR_ONE);
      push_number(2);
      push_number(99999);
      push_byte(random_non_hash());
      push_tick();
      push_tick();
      push_byte(HASH_BYTE);
      push_byte(CHAR_TWO);
      push_byte(CHAR_TWO);
      repeat (5) push_byte(SLASH_BYTE);
      push_number(0);
      push_tick();
      push_byte(HASH_BYTE);
      push_tick();
      push_byte(CHAR_TWO);
      push_byte(8'hFF);
      push_number(0);
      push_number(60000);
      push_byte(HASH_BYTE);
      push_byte(CHAR_THREE);

      while (serial_feed_q.size() < ItemTarget) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            // move command, mostly well-formed, followed by ticks and some noise
            push_byte(HASH_BYTE);
            push_byte(CHAR_TWO);
            sel = $urandom_range(0, 99);
            if (sel < 45)
               dir = CHAR_ONE;
            else if (sel < 90)
               dir = CHAR_TWO;
            else
               dir = ByteW'($urandom);
            push_byte(dir);
            sel = $urandom_range(0, 99);
            if (sel < 85)
               push_number($urandom_range(0, 12));
            else if (sel < 95)
               push_raw_digits();
            else
               push_number($urandom_range(0, 99999));
            sel = $urandom_range(0, 99);
            if (sel < 80)
               push_number($urandom_range(6000, 99999));
            else if (sel < 90)
               push_number($urandom_range(0, 3000));
            else
               push_raw_digits();
            repeat ($urandom_range(4, 50)) begin
               sel = $urandom_range(0, 99);
               if (sel < 85)
                  push_tick();
               else if (sel < 97)
                  push_byte(random_non_hash());
               else
                  push_byte(HASH_BYTE);
            end
            if ($urandom_range(0, 4) == 0) begin
               push_byte(HASH_BYTE);
               push_byte(ByteW'($urandom));
            end
         end else if (pick < 85) begin
            // broken command sequences
            push_byte(HASH_BYTE);
            sel = $urandom_range(0, 3);
            if (sel == 0) begin
               push_byte(CHAR_ONE);
            end else if (sel == 1) begin
               push_byte(CHAR_THREE);
            end else if (sel == 2) begin
               push_byte(ByteW'($urandom));
            end else begin
               push_byte(CHAR_TWO);
               repeat ($urandom_range(1, 10)) push_byte(ByteW'($urandom));
            end
         end else begin
            repeat ($urandom_range(1, 5)) begin
               if ($urandom_range(0, 1) == 0)
                  push_tick();
               else
                  push_byte(ByteW'($urandom));
            end
         end
      end
      total_items = serial_feed_q.size();

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      wait (accepted_count == total_items);
      wait (expected_drive_q.size() == 0);
      repeat (DrainCycles) @(posedge clock);

      $display("run covered %0d ticks and %0d serial bytes, %0d responses checked",
               tick_count, byte_count, checked_count);
      $display("%0d parameter sets decoded, %0d motor steps completed, %0d mismatches",
               sets_decoded, steps_done, mismatch_count);
      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

/* serial_stepper_wave_drive_sequencer.f */
sv/ssw_pkg.sv
sv/ssw_req_if.sv
sv/ssw_rsp_if.sv
sv/ssw_div.sv
sv/serial_stepper_wave_drive_sequencer.sv
bench/tb_top.sv
